@@ hw/rtl/cor_pkg.sv @@
// shared types and constants for the circle octant rasterizer
package cor_pkg;

   localparam int PIX_W       = 12;
   localparam int COLOR_W     = 3;
   localparam int OCT_W       = 3;
   localparam int QUEUE_DEPTH = 2;

   localparam int DEC_START    = 3;
   localparam int DEC_DOWN_ADD = 10;
   localparam int DEC_HOLD_ADD = 6;

   localparam logic [OCT_W-1:0] LAST_OCT = 3'd7;

   typedef enum logic {
      MODE_START = 1'b0,
      MODE_STEP  = 1'b1
   } mode_type;

   typedef enum logic [OCT_W-1:0] {
      OCT_PX_PY = 3'd0,
      OCT_NX_PY = 3'd1,
      OCT_PX_NY = 3'd2,
      OCT_NX_NY = 3'd3,
      OCT_NY_PX = 3'd4,
      OCT_NY_NX = 3'd5,
      OCT_PY_PX = 3'd6,
      OCT_PY_NX = 3'd7
   } oct_type;

   typedef struct packed {
      logic [PIX_W-1:0]   cx;
      logic [PIX_W-1:0]   cy;
      logic [PIX_W-1:0]   ox;
      logic [PIX_W-1:0]   oy;
      logic [COLOR_W-1:0] color;
      logic               done;
   } run_type;

endpackage

@@ hw/rtl/cor_front.sv @@
// front end: takes start and step items, runs the midpoint decision, issues runs
module cor_front import cor_pkg::*; #(
   parameter int RADIUS_BITS = 9,
   parameter int COORD_BITS  = 10
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept_i,
   input  logic                   mode_i,
   input  logic [COORD_BITS-1:0]  center_x_i,
   input  logic [COORD_BITS-1:0]  center_y_i,
   input  logic [RADIUS_BITS-1:0] radius_i,
   input  logic [COLOR_W-1:0]     color_index_i,
   output logic                   run_valid_o,
   output run_type                run_o
);

   localparam int OFF_W = RADIUS_BITS + 2;
   localparam int DEC_W = RADIUS_BITS + 5;

   logic [COORD_BITS-1:0] center_col_ff, center_col_in;
   logic [COORD_BITS-1:0] center_row_ff, center_row_in;
   logic [COLOR_W-1:0]    held_color_ff, held_color_in;
   logic signed [OFF_W-1:0] offset_x_ff, offset_x_in;
   logic signed [OFF_W-1:0] offset_y_ff, offset_y_in;
   logic signed [DEC_W-1:0] decision_ff, decision_in;
   logic active_ff, active_in;

   logic                    is_start;
   logic                    step_ok;
   logic                    dec_pos;
   logic signed [OFF_W-1:0] step_x;
   logic signed [OFF_W-1:0] step_y;
   logic signed [DEC_W-1:0] step_diff;
   logic signed [DEC_W-1:0] step_dec;
   logic                    step_done;

   assign is_start = (mode_i == MODE_START);
   assign step_ok  = active_ff && !(offset_y_ff < offset_x_ff);
   assign dec_pos  = !decision_ff[DEC_W-1] && (decision_ff != '0);

   // one midpoint step
   always_comb begin
      step_x = offset_x_ff + OFF_W'(1);
      if (dec_pos) begin
         step_y    = offset_y_ff - OFF_W'(1);
         step_diff = DEC_W'(step_x) - DEC_W'(step_y);
         step_dec  = decision_ff + (step_diff <<< 2) + DEC_W'(DEC_DOWN_ADD);
      end else begin
         step_y    = offset_y_ff;
         step_diff = DEC_W'(step_x);
         step_dec  = decision_ff + (step_diff <<< 2) + DEC_W'(DEC_HOLD_ADD);
      end
      step_done = (step_y < step_x);
   end

   always_comb begin
      center_col_in = center_col_ff;
      center_row_in = center_row_ff;
      held_color_in = held_color_ff;
      offset_x_in   = offset_x_ff;
      offset_y_in   = offset_y_ff;
      decision_in   = decision_ff;
      active_in     = active_ff;
      if (accept_i && is_start) begin
         center_col_in = center_x_i;
         center_row_in = center_y_i;
         held_color_in = color_index_i;
         offset_x_in   = '0;
         offset_y_in   = OFF_W'(radius_i);
         decision_in   = DEC_W'(DEC_START) - (DEC_W'(radius_i) <<< 1);
         active_in     = 1'b1;
      end else if (accept_i && step_ok) begin
         offset_x_in = step_x;
         offset_y_in = step_y;
         decision_in = step_dec;
         active_in   = !step_done;
      end
   end

   always_comb begin
      run_valid_o = accept_i && (is_start || step_ok);
      run_o.cx    = PIX_W'(center_col_in);
      run_o.cy    = PIX_W'(center_row_in);
      run_o.ox    = PIX_W'(offset_x_in);
      run_o.oy    = PIX_W'(offset_y_in);
      run_o.color = held_color_in;
      run_o.done  = !is_start && step_done;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
      end else begin
         active_ff <= active_in;
      end
   end

   always_ff @(posedge clock) begin
      center_col_ff <= center_col_in;
      center_row_ff <= center_row_in;
      held_color_ff <= held_color_in;
      offset_x_ff   <= offset_x_in;
      offset_y_ff   <= offset_y_in;
      decision_ff   <= decision_in;
   end

endmodule

@@ hw/rtl/cor_queue.sv @@
// short run queue between front and back
module cor_queue import cor_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    wr_valid_i,
   input  run_type wr_data_i,
   output logic    full_o,
   output logic    rd_valid_o,
   output run_type rd_data_o,
   input  logic    rd_pop_i
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   run_type slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   logic do_wr;
   logic do_rd;

   assign full_o     = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign rd_valid_o = (count_ff != '0);
   assign rd_data_o  = slot_ff[rd_ptr_ff];
   assign do_wr      = wr_valid_i && !full_o;
   assign do_rd      = rd_pop_i && rd_valid_o;

   always_comb begin
      wr_ptr_in = do_wr ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_rd ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + CNT_W'(do_wr) - CNT_W'(do_rd);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         slot_ff[wr_ptr_ff] <= wr_data_i;
      end
   end

endmodule

@@ hw/rtl/cor_back.sv @@
// back end: expands each run into eight symmetric pixels, one per cycle while the output is popped
module cor_back import cor_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               run_valid_i,
   input  run_type            run_i,
   output logic               run_pop_o,
   output logic               empty_o,
   input  logic               pop_i,
   output logic [PIX_W-1:0]   pixel_x_o,
   output logic [PIX_W-1:0]   pixel_y_o,
   output logic [COLOR_W-1:0] pixel_color_o,
   output logic               last_o,
   output logic               done_o
);

   oct_type oct_ff, oct_in;
   logic out_valid_ff, out_valid_in;
   logic [PIX_W-1:0]   pixel_x_ff, pixel_x_in;
   logic [PIX_W-1:0]   pixel_y_ff, pixel_y_in;
   logic [COLOR_W-1:0] color_ff;
   logic               last_ff;
   logic               done_ff;

   logic             load;
   logic [PIX_W-1:0] add_x;
   logic [PIX_W-1:0] add_y;

   assign load      = run_valid_i && (!out_valid_ff || pop_i);
   assign run_pop_o = load && (oct_ff == LAST_OCT);

   always_comb begin
      unique case (oct_ff)
         OCT_PX_PY: begin add_x =  run_i.ox; add_y =  run_i.oy; end
         OCT_NX_PY: begin add_x = -run_i.ox; add_y =  run_i.oy; end
         OCT_PX_NY: begin add_x =  run_i.ox; add_y = -run_i.oy; end
         OCT_NX_NY: begin add_x = -run_i.ox; add_y = -run_i.oy; end
         OCT_NY_PX: begin add_x = -run_i.oy; add_y =  run_i.ox; end
         OCT_NY_NX: begin add_x = -run_i.oy; add_y = -run_i.ox; end
         OCT_PY_PX: begin add_x =  run_i.oy; add_y =  run_i.ox; end
         OCT_PY_NX: begin add_x =  run_i.oy; add_y = -run_i.ox; end
         default:   begin add_x = '0;        add_y = '0;        end
      endcase
      pixel_x_in = run_i.cx + add_x;
      pixel_y_in = run_i.cy + add_y;
   end

   always_comb begin
      oct_in       = load ? oct_type'(oct_ff + OCT_W'(1)) : oct_ff;
      out_valid_in = load || (out_valid_ff && !pop_i);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         oct_ff       <= OCT_PX_PY;
         out_valid_ff <= 1'b0;
      end else begin
         oct_ff       <= oct_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         pixel_x_ff <= pixel_x_in;
         pixel_y_ff <= pixel_y_in;
         color_ff   <= run_i.color;
         last_ff    <= (oct_ff == LAST_OCT);
         done_ff    <= run_i.done;
      end
   end

   assign empty_o       = !out_valid_ff;
   assign pixel_x_o     = pixel_x_ff;
   assign pixel_y_o     = pixel_y_ff;
   assign pixel_color_o = color_ff;
   assign last_o        = last_ff;
   assign done_o        = done_ff;

   a_pop_needs_run: assert property (@(posedge clock) disable iff (reset)
      run_pop_o |-> run_valid_i)
      else $error("run released from an empty queue");

   a_pop_restarts: assert property (@(posedge clock) disable iff (reset)
      run_pop_o |=> (oct_ff == OCT_PX_PY) && out_valid_ff && last_ff)
      else $error("run release out of step with last pixel");

   a_last_matches_oct: assert property (@(posedge clock) disable iff (reset)
      load |=> (last_ff == ($past(oct_ff) == LAST_OCT)))
      else $error("last flag not on eighth pixel");

endmodule

@@ hw/rtl/circle_octant_rasterizer_top.sv @@
// top level of the circle octant rasterizer
// Bresenham circle rasterizer with eight-way symmetry. A start item (mode 0)
// loads center, radius and color and sends the eight pixels of the first point;
// each step item (mode 1) advances one point and sends eight more, the eighth
// marked last, with done_res set on every pixel of the step that completes the
// circle. A step while no circle is active sends nothing. Results leave at one
// pixel per cycle from the output register while pop is held; that rate is set
// by the pixel expander in the back end, which sends eight pixels per item.
// Items are taken in consecutive cycles while the two-entry run queue between
// the decision front end and the expander has room, and the first pixel of an
// item passes through a queue slot and the output register before it can be popped.
module circle_octant_rasterizer_top import cor_pkg::*; #(
   parameter int RADIUS_BITS = 9,
   parameter int COORD_BITS  = 10
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   output logic                      full,
   input  logic                      req_mode,
   input  logic [COORD_BITS-1:0]     req_center_x,
   input  logic [COORD_BITS-1:0]     req_center_y,
   input  logic [RADIUS_BITS-1:0]    req_radius,
   input  logic [COLOR_W-1:0]        req_color_index,
   output logic                      empty,
   input  logic                      pop,
   output logic signed [PIX_W-1:0]   rsp_pixel_x,
   output logic signed [PIX_W-1:0]   rsp_pixel_y,
   output logic [COLOR_W-1:0]        rsp_pixel_color,
   output logic                      rsp_last,
   output logic                      rsp_done_res
);

   logic    req_transfer;
   logic    front_valid;
   run_type front_run;
   logic    queue_valid;
   run_type queue_run;
   logic    queue_pop;
   logic [PIX_W-1:0] pixel_x;
   logic [PIX_W-1:0] pixel_y;

   assign req_transfer = push && !full;

   cor_front #(
      .RADIUS_BITS (RADIUS_BITS),
      .COORD_BITS  (COORD_BITS)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .accept_i      (req_transfer),
      .mode_i        (req_mode),
      .center_x_i    (req_center_x),
      .center_y_i    (req_center_y),
      .radius_i      (req_radius),
      .color_index_i (req_color_index),
      .run_valid_o   (front_valid),
      .run_o         (front_run)
   );

   cor_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .wr_valid_i (front_valid),
      .wr_data_i  (front_run),
      .full_o     (full),
      .rd_valid_o (queue_valid),
      .rd_data_o  (queue_run),
      .rd_pop_i   (queue_pop)
   );

   cor_back u_back (
      .clock         (clock),
      .reset         (reset),
      .run_valid_i   (queue_valid),
      .run_i         (queue_run),
      .run_pop_o     (queue_pop),
      .empty_o       (empty),
      .pop_i         (pop),
      .pixel_x_o     (pixel_x),
      .pixel_y_o     (pixel_y),
      .pixel_color_o (rsp_pixel_color),
      .last_o        (rsp_last),
      .done_o        (rsp_done_res)
   );

   assign rsp_pixel_x = pixel_x;
   assign rsp_pixel_y = pixel_y;

endmodule

@@ sim/circle_octant_rasterizer_top_test.sv @@
// self-checking testbench for the circle octant rasterizer: random bursts, stalls and pixel compare
`timescale 1ns / 1ps

module circle_octant_rasterizer_top_test import cor_pkg::*;;

   localparam int COORD_W = 10;
   localparam int RAD_W   = 9;
   localparam int RANDOM_ITEMS = 230;

   typedef struct packed {
      mode_type           mode;
      logic [COORD_W-1:0] cx;
      logic [COORD_W-1:0] cy;
      logic [RAD_W-1:0]   radius;
      logic [COLOR_W-1:0] color;
   } circle_cmd_type;

   typedef struct packed {
      logic [PIX_W-1:0]   px;
      logic [PIX_W-1:0]   py;
      logic [COLOR_W-1:0] color;
      logic               last;
      logic               done;
   } pixel_type;

   typedef struct packed {
      logic [COORD_W-1:0] ccol;
      logic [COORD_W-1:0] crow;
      logic [COLOR_W-1:0] color;
      logic [31:0]        ox;
      logic [31:0]        oy;
      logic [31:0]        dec;
      logic               active;
   } circle_state_type;

   logic                      clock;
   logic                      reset;
   logic                      push;
   logic                      full;
   logic                      req_mode;
   logic [COORD_W-1:0]        req_center_x;
   logic [COORD_W-1:0]        req_center_y;
   logic [RAD_W-1:0]          req_radius;
   logic [COLOR_W-1:0]        req_color_index;
   logic                      empty;
   logic                      pop;
   logic signed [PIX_W-1:0]   rsp_pixel_x;
   logic signed [PIX_W-1:0]   rsp_pixel_y;
   logic [COLOR_W-1:0]        rsp_pixel_color;
   logic                      rsp_last;
   logic                      rsp_done_res;

   circle_octant_rasterizer_top #(
      .RADIUS_BITS(RAD_W),
      .COORD_BITS (COORD_W)
   ) dut (
      .clock          (clock),
      .reset          (reset),
      .push           (push),
      .full           (full),
      .req_mode       (req_mode),
      .req_center_x   (req_center_x),
      .req_center_y   (req_center_y),
      .req_radius     (req_radius),
      .req_color_index(req_color_index),
      .empty          (empty),
      .pop            (pop),
      .rsp_pixel_x    (rsp_pixel_x),
      .rsp_pixel_y    (rsp_pixel_y),
      .rsp_pixel_color(rsp_pixel_color),
      .rsp_last       (rsp_last),
      .rsp_done_res   (rsp_done_res)
   );

   circle_cmd_type   pending_cmds[$];
   pixel_type        expected_pixels[$];
   circle_state_type plan_state;
   circle_state_type model_state;

   int errors;
   int pixels_checked;
   int cmds_taken;
   int circles_planned;
   int steps_planned;
   int idle_steps_planned;
   int emitting_cmds;
   bit req_taken;

   int burst_left;
   int gap_left;
   int hold_left;
   bit hold_used;
   int pop_pattern;
   int phase_left;

   circle_cmd_type  drive_cmd;
   circle_cmd_type  seen_cmd;
   pixel_type [7:0] seen_run;
   pixel_type [7:0] plan_run;
   pixel_type       want;
   int              seen_count;

   // one bresenham update (or a start load) plus the eight mirrored pixels of the resulting point
   function automatic int rasterize(inout circle_state_type st, input circle_cmd_type cmd,
                                    output pixel_type [7:0] run);
      int x;
      int y;
      int d;
      int r;
      int cx;
      int cy;
      int px;
      int py;
      logic done;
      run = '0;
      done = 1'b0;
      if (cmd.mode == MODE_START) begin
         r = int'(cmd.radius);
         st.ccol   = cmd.cx;
         st.crow   = cmd.cy;
         st.color  = cmd.color;
         st.ox     = 0;
         st.oy     = r;
         st.dec    = DEC_START - 2 * r;
         st.active = 1'b1;
      end else begin
         x = st.ox;
         y = st.oy;
         d = st.dec;
         if (!st.active || y < x) return 0;
         x = x + 1;
         if (d > 0) begin
            y = y - 1;
            d = d + 4 * (x - y) + DEC_DOWN_ADD;
         end else begin
            d = d + 4 * x + DEC_HOLD_ADD;
         end
         done = (y < x);
         if (done) st.active = 1'b0;
         st.ox  = x;
         st.oy  = y;
         st.dec = d;
      end
      x  = st.ox;
      y  = st.oy;
      cx = int'(st.ccol);
      cy = int'(st.crow);
      for (int k = 0; k < 8; k++) begin
         case (oct_type'(k))
            OCT_PX_PY: begin px = cx + x; py = cy + y; end
            OCT_NX_PY: begin px = cx - x; py = cy + y; end
            OCT_PX_NY: begin px = cx + x; py = cy - y; end
            OCT_NX_NY: begin px = cx - x; py = cy - y; end
            OCT_NY_PX: begin px = cx - y; py = cy + x; end
            OCT_NY_NX: begin px = cx - y; py = cy - x; end
            OCT_PY_PX: begin px = cx + y; py = cy + x; end
            default:   begin px = cx + y; py = cy - x; end
         endcase
         run[k].px    = px[PIX_W-1:0];
         run[k].py    = py[PIX_W-1:0];
         run[k].color = st.color;
         run[k].last  = (oct_type'(k) == OCT_PY_NX);
         run[k].done  = done;
      end
      return 8;
   endfunction

   task automatic queue_cmd(input mode_type mode, input int cx, input int cy,
                            input int radius, input int color);
      circle_cmd_type cmd;
      cmd.mode   = mode;
      cmd.cx     = COORD_W'(cx);
      cmd.cy     = COORD_W'(cy);
      cmd.radius = RAD_W'(radius);
      cmd.color  = COLOR_W'(color);
      pending_cmds.push_back(cmd);
      if (mode == MODE_START) circles_planned++;
      if (rasterize(plan_state, cmd, plan_run) > 0) begin
         emitting_cmds++;
         if (mode == MODE_STEP) steps_planned++;
      end else begin
         idle_steps_planned++;
      end
   endtask

   task automatic queue_random(input mode_type mode);
      int sel;
      int cx;
      int cy;
      int radius;
      int color;
      sel = $urandom_range(0, 7);
      cx = (sel == 0) ? 0 : (sel == 1) ? 1023 : $urandom_range(0, 1023);
      sel = $urandom_range(0, 7);
      cy = (sel == 0) ? 0 : (sel == 1) ? 1023 : $urandom_range(0, 1023);
      sel = $urandom_range(0, 99);
      if (sel < 80) radius = $urandom_range(0, 12);
      else if (sel < 97) radius = $urandom_range(13, 60);
      else radius = $urandom_range(61, 511);
      color = ($urandom_range(0, 4) != 0) ? $urandom_range(0, 4) : $urandom_range(5, 7);
      queue_cmd(mode, cx, cy, radius, color);
   endtask

   function automatic void check_field(input string name, input int want_v, input int got_v);
      if (want_v != got_v) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want_v, got_v);
         errors++;
      end
   endfunction

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // predictor on input transfers, checker on output transfers
   always @(posedge clock) begin
      if (reset) begin
         req_taken = 1'b0;
      end else begin
         req_taken = push && !full;
         if (req_taken) begin
            seen_cmd.mode   = mode_type'(req_mode);
            seen_cmd.cx     = req_center_x;
            seen_cmd.cy     = req_center_y;
            seen_cmd.radius = req_radius;
            seen_cmd.color  = req_color_index;
            seen_count = rasterize(model_state, seen_cmd, seen_run);
            for (int k = 0; k < seen_count; k++) expected_pixels.push_back(seen_run[k]);
            cmds_taken++;
         end
         if (pop && !empty) begin
            if (expected_pixels.size() == 0) begin
               $display("%0t: pixel (%0d,%0d) arrived with none expected",
                        $time, rsp_pixel_x, rsp_pixel_y);
               errors++;
            end else begin
               want = expected_pixels.pop_front();
               check_field("pixel_x", $signed(want.px), rsp_pixel_x);
               check_field("pixel_y", $signed(want.py), rsp_pixel_y);
               check_field("pixel_color", want.color, rsp_pixel_color);
               check_field("last", want.last, rsp_last);
               check_field("done_res", want.done, rsp_done_res);
               pixels_checked++;
            end
         end
      end
   end

   // sender: bursts of transfers with random gaps
   always @(negedge clock) begin
      if (reset) begin
         push <= 1'b0;
      end else if (push && !req_taken) begin
         // item still waiting for its transfer
      end else if (gap_left > 0) begin
         gap_left--;
         push <= 1'b0;
      end else if (pending_cmds.size() > 0) begin
         drive_cmd = pending_cmds.pop_front();
         req_mode        <= drive_cmd.mode;
         req_center_x    <= drive_cmd.cx;
         req_center_y    <= drive_cmd.cy;
         req_radius      <= drive_cmd.radius;
         req_color_index <= drive_cmd.color;
         push <= 1'b1;
         if (burst_left > 0) begin
            burst_left--;
         end else begin
            burst_left = $urandom_range(1, 30);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         end
      end else begin
         push <= 1'b0;
      end
   end

   // receiver: own stall pattern plus one long hold-off to back up the input
   always @(negedge clock) begin
      if (reset) begin
         pop <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         pop <= 1'b0;
      end else if (!hold_used && cmds_taken >= 40) begin
         hold_used = 1'b1;
         hold_left = 400;
         pop <= 1'b0;
      end else begin
         if (phase_left == 0) begin
            pop_pattern = $urandom_range(0, 3);
            phase_left = $urandom_range(16, 80);
         end
         phase_left--;
         case (pop_pattern)
            0:       pop <= 1'b1;
            1:       pop <= 1'($urandom_range(0, 1));
            2:       pop <= (phase_left % 4 == 0);
            default: pop <= (phase_left < 5);
         endcase
      end
   end

   initial begin
      #2_000_000;
      $display("FAILURE");
      $finish;
   end

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      push = 1'b0;
      pop = 1'b0;
      req_mode = MODE_START;
      req_center_x = '0;
      req_center_y = '0;
      req_radius = '0;
      req_color_index = '0;
      errors = 0;
      pixels_checked = 0;
      cmds_taken = 0;
      circles_planned = 0;
      steps_planned = 0;
      idle_steps_planned = 0;
      emitting_cmds = 0;
      req_taken = 1'b0;
      burst_left = 0;
      gap_left = 0;
      hold_left = 0;
      hold_used = 1'b0;
      pop_pattern = 0;
      phase_left = 0;
      plan_state = '0;
      model_state = '0;

      // directed: idle step, zero radius, extremes, restart while active
      queue_cmd(MODE_STEP, 1023, 1023, 511, 7);
      queue_cmd(MODE_START, 0, 0, 0, 0);
      queue_cmd(MODE_STEP, 0, 0, 0, 0);
      queue_cmd(MODE_STEP, 1023, 0, 511, 3);
      queue_cmd(MODE_START, 1023, 1023, 511, 7);
      queue_cmd(MODE_STEP, 0, 0, 0, 0);
      queue_cmd(MODE_STEP, 1023, 1023, 511, 7);
      queue_cmd(MODE_START, 0, 1023, 1, 4);
      queue_cmd(MODE_STEP, 0, 0, 0, 0);
      queue_cmd(MODE_STEP, 0, 0, 0, 0);
      queue_cmd(MODE_START, 512, 511, 2, 5);
      repeat (3) queue_cmd(MODE_STEP, 0, 0, 0, 0);
      queue_cmd(MODE_START, 'h155, 'h2aa, 3, 6);
      repeat (4) queue_cmd(MODE_STEP, 'h2aa, 'h155, 'h0aa, 1);
      queue_cmd(MODE_START, 1023, 0, 8, 2);
      repeat (6) queue_cmd(MODE_STEP, 0, 1023, 'h155, 0);

      // random: mostly whole circles, some restarts and idle steps
      emitting_cmds = 0;
      while (emitting_cmds < RANDOM_ITEMS) begin
         if (!plan_state.active) begin
            if ($urandom_range(0, 9) == 0) queue_random(MODE_STEP);
            else queue_random(MODE_START);
         end else if ($urandom_range(0, 99) < 94) begin
            queue_random(MODE_STEP);
         end else begin
            queue_random(MODE_START);
         end
      end

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      while (pending_cmds.size() != 0 || push) @(posedge clock);
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("run covered %0d circles, %0d drawing steps and %0d steps with no circle",
               circles_planned, steps_planned, idle_steps_planned);
      $display("%0d input transfers, %0d pixels compared, %0d left unseen",
               cmds_taken, pixels_checked, expected_pixels.size());
      if (errors == 0 && expected_pixels.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
